/* rtl/skvt_pkg.sv */
`default_nettype none

package skvt_pkg;

	localparam int DEF_CAPACITY    = 16;
	localparam int DEF_KEY_WIDTH   = 32;
	localparam int DEF_VALUE_WIDTH = 32;

	// fixed width of the entry_count result field
	localparam int COUNT_OUT_W = 5;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SEARCH = 2'd2
	} skvt_req_t;

	// outcome of comparing one stored key against the request key
	typedef struct packed {
		logic eq;   // keys are equal
		logic rel;  // stored key may stay ahead of the request key
	} skvt_cmp_t;

endpackage

`default_nettype wire

/* rtl/skvt_mem.sv */
`default_nettype none

module skvt_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/skvt_cmp.sv */
`default_nettype none

module skvt_cmp #(
	parameter int KEY_WIDTH = 32
) (
	input  wire logic signed [KEY_WIDTH-1:0] entry_key,
	input  wire logic signed [KEY_WIDTH-1:0] req_key,
	input  wire logic                        descending,
	output skvt_pkg::skvt_cmp_t              res
);
	import skvt_pkg::*;

	always_comb begin
		res.eq  = (entry_key == req_key);
		res.rel = descending ? (entry_key >= req_key) : (entry_key <= req_key);
	end

endmodule

`default_nettype wire

/* rtl/sorted_key_value_table.sv */
`default_nettype none

// Channel   Handshake             Payload
// request   in_valid / in_ready   req_type, key, value
// result    out_valid / out_ready found, old_value, entry_count, table_full_error
// config    cfg_we                cfg_wdata (sort order, 1 = descending)
//
// One request at a time. A request scans the pair memory one entry per cycle
// on its single read port and then decides in the action state. An insert
// then moves any entries above its place up and writes the pair, a remove
// moves any entries above the removed one down. The result stage posts the
// result and the idle state takes the next request. Reset empties the table
// with no clearing pass. A stalled result holds in the output register while
// the next request already runs; it waits only at its own result stage.

module sorted_key_value_table #(
	parameter int CAPACITY    = skvt_pkg::DEF_CAPACITY,
	parameter int KEY_WIDTH   = skvt_pkg::DEF_KEY_WIDTH,
	parameter int VALUE_WIDTH = skvt_pkg::DEF_VALUE_WIDTH
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic                                   cfg_wdata,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [1:0]                             req_type,
	input  wire logic signed [KEY_WIDTH-1:0]            key,
	input  wire logic signed [VALUE_WIDTH-1:0]          value,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic                                        found,
	output logic signed [VALUE_WIDTH-1:0]               old_value,
	output logic [skvt_pkg::COUNT_OUT_W-1:0]            entry_count,
	output logic                                        table_full_error
);
	import skvt_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PAIR_W = KEY_WIDTH + VALUE_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ACT,
		S_SHUP,
		S_INS,
		S_SHDN,
		S_DONE
	} state_t;

	state_t                         state_q;
	logic [1:0]                     req_q;
	logic signed [KEY_WIDTH-1:0]    key_q;
	logic signed [VALUE_WIDTH-1:0]  val_q;
	logic                           hit_q;
	logic [IDX_W-1:0]               hit_idx_q;
	logic                           pos_found_q;
	logic [CNT_W-1:0]               pos_q;
	logic signed [VALUE_WIDTH-1:0]  old_q;
	logic                           full_q;
	logic [IDX_W-1:0]               idx_q;
	logic [CNT_W-1:0]               count_q;
	logic                           sort_q;

	logic                           out_valid_q;
	logic                           found_q;
	logic signed [VALUE_WIDTH-1:0]  old_value_q;
	logic [COUNT_OUT_W-1:0]         entry_count_q;
	logic                           table_full_error_q;

	logic                           mem_we;
	logic [IDX_W-1:0]               mem_waddr;
	logic [PAIR_W-1:0]              mem_wdata;
	logic [IDX_W-1:0]               mem_raddr;
	logic [PAIR_W-1:0]              mem_rdata;
	logic signed [KEY_WIDTH-1:0]    rd_key;
	logic signed [VALUE_WIDTH-1:0]  rd_val;
	skvt_cmp_t                      cmp;

	logic [CNT_W-1:0]               idx_ext;
	logic [CNT_W-1:0]               last_ext;
	logic [IDX_W-1:0]               last_idx;
	logic                           tbl_full;
	logic                           req_known;

	assign rd_key = mem_rdata[PAIR_W-1:VALUE_WIDTH];
	assign rd_val = mem_rdata[VALUE_WIDTH-1:0];

	assign idx_ext   = CNT_W'(idx_q);
	assign last_ext  = count_q - CNT_W'(1);
	assign last_idx  = IDX_W'(last_ext);
	assign tbl_full  = (count_q == CNT_W'(CAPACITY));
	assign req_known = req_q inside {REQ_ADD, REQ_REMOVE, REQ_SEARCH};

	skvt_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (PAIR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	skvt_cmp #(
		.KEY_WIDTH (KEY_WIDTH)
	) u_cmp (
		.entry_key  (rd_key),
		.req_key    (key_q),
		.descending (sort_q),
		.res        (cmp)
	);

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = hit_idx_q;
		mem_wdata = {key_q, val_q};
		mem_raddr = '0;
		case (state_q)
			S_SCAN: begin
				mem_raddr = idx_q + IDX_W'(1);
			end
			S_ACT: begin
				if (req_q == REQ_ADD) begin
					if (hit_q) begin
						mem_we = 1'b1;
					end else if (!tbl_full) begin
						if (pos_q == count_q) begin
							mem_we    = 1'b1;
							mem_waddr = IDX_W'(count_q);
						end else begin
							mem_raddr = last_idx;
						end
					end
				end else if (req_q == REQ_REMOVE && hit_q) begin
					mem_raddr = hit_idx_q + IDX_W'(1);
				end
			end
			S_SHUP: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q + IDX_W'(1);
				mem_wdata = mem_rdata;
				mem_raddr = idx_q - IDX_W'(1);
			end
			S_INS: begin
				mem_we    = 1'b1;
				mem_waddr = IDX_W'(pos_q);
			end
			S_SHDN: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q - IDX_W'(1);
				mem_wdata = mem_rdata;
				mem_raddr = idx_q + IDX_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= S_IDLE;
			req_q              <= '0;
			key_q              <= '0;
			val_q              <= '0;
			hit_q              <= 1'b0;
			hit_idx_q          <= '0;
			pos_found_q        <= 1'b0;
			pos_q              <= '0;
			old_q              <= '0;
			full_q             <= 1'b0;
			idx_q              <= '0;
			count_q            <= '0;
			sort_q             <= 1'b0;
			out_valid_q        <= 1'b0;
			found_q            <= 1'b0;
			old_value_q        <= '0;
			entry_count_q      <= '0;
			table_full_error_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				sort_q <= cfg_wdata;
			end
			// the result stage handles the output register itself
			if (out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q       <= req_type;
						key_q       <= key;
						val_q       <= value;
						hit_q       <= 1'b0;
						pos_found_q <= 1'b0;
						pos_q       <= count_q;
						old_q       <= '0;
						full_q      <= 1'b0;
						idx_q       <= '0;
						state_q     <= (count_q == '0) ? S_ACT : S_SCAN;
					end
				end
				S_SCAN: begin
					// rd data belongs to entry idx_q
					if (cmp.eq && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_q;
						old_q     <= rd_val;
					end
					if (!cmp.rel && !pos_found_q) begin
						pos_found_q <= 1'b1;
						pos_q       <= idx_ext;
					end
					idx_q <= idx_q + IDX_W'(1);
					if (idx_ext == last_ext) begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					if (req_q == REQ_ADD) begin
						if (hit_q) begin
							state_q <= S_DONE;
						end else if (tbl_full) begin
							full_q  <= 1'b1;
							state_q <= S_DONE;
						end else if (pos_q == count_q) begin
							count_q <= count_q + CNT_W'(1);
							state_q <= S_DONE;
						end else begin
							idx_q   <= last_idx;
							state_q <= S_SHUP;
						end
					end else if (req_q == REQ_REMOVE && hit_q) begin
						if (hit_idx_q == last_idx) begin
							count_q <= last_ext;
							state_q <= S_DONE;
						end else begin
							idx_q   <= hit_idx_q + IDX_W'(1);
							state_q <= S_SHDN;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SHUP: begin
					if (idx_q == IDX_W'(pos_q)) begin
						state_q <= S_INS;
					end else begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				S_INS: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_SHDN: begin
					if (idx_ext == last_ext) begin
						count_q <= last_ext;
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q        <= 1'b1;
						found_q            <= hit_q && req_known;
						old_value_q        <= (hit_q && req_known) ? old_q : '0;
						entry_count_q      <= COUNT_OUT_W'(count_q);
						table_full_error_q <= full_q;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready         = (state_q == S_IDLE);
	assign out_valid        = out_valid_q;
	assign found            = found_q;
	assign old_value        = old_value_q;
	assign entry_count      = entry_count_q;
	assign table_full_error = table_full_error_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("pair count above capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in flight");

	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && table_full_error))
		else $error("full error reported for a held key");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHUP) |-> (idx_ext < count_q) && (idx_ext >= pos_q))
		else $error("insert shift index out of range");
`endif

endmodule

`default_nettype wire
